@@ src/periodic_grid_central_difference_defines.svh @@
// Assertion macros for the grid stencil top level.
`ifndef PERIODIC_GRID_CENTRAL_DIFFERENCE_DEFINES_SVH
`define PERIODIC_GRID_CENTRAL_DIFFERENCE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PGCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgcd same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define PGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgcd next-cycle check failed");
`else
`define PGCD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/pgcd_pkg.sv @@
// Shared types and constants of the periodic grid stencil.
package pgcd_pkg;

  localparam int GRID_SIDE_DEF = 64;
  localparam int WORD_W        = 32;
  localparam int ROW_W         = 6;
  localparam int COL_W         = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int DIFF_W        = 35;
  localparam int MAG_W         = 34;
  localparam int SCALE_LAT     = 4;

  localparam logic [WORD_W-1:0] INV_RESET = 32'h0001_0000;

  // Action codes of an input word
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TWO_STEP     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_SQUARED = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [WORD_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] first_along_rows;
    logic signed [WORD_W-1:0] first_along_cols;
    logic signed [WORD_W-1:0] second_along_rows;
    logic signed [WORD_W-1:0] second_along_cols;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MATH,
    ST_DONE
  } pgcd_state_t;

endpackage

@@ src/pgcd_scale.sv @@
// Four-stage scaler: magnitude times Q16.16 factor, round, restore sign, saturate.
module pgcd_scale (
  input  logic                                clk,
  input  logic signed [pgcd_pkg::DIFF_W-1:0]  diff,
  input  logic [pgcd_pkg::WORD_W-1:0]         factor,
  output logic signed [pgcd_pkg::WORD_W-1:0]  result
);
  import pgcd_pkg::*;

  localparam int HALF_W = WORD_W / 2;
  localparam int PROD_W = MAG_W + HALF_W;
  localparam int Q_W    = PROD_W + 1;

  localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(64'h8000_0000);
  localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(64'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h8000);

  logic                     neg_r;
  logic [MAG_W-1:0]         mag_r;
  logic [WORD_W-1:0]        fac_r;
  logic [MAG_W-1:0]         lo_r;
  logic [Q_W-1:0]           q_r;
  logic [WORD_W-1:0]        res_r;
  logic [PROD_W-1:0]        lo_prod;
  logic [WORD_W-1:0]        res_nxt;

  // Take the magnitude of the difference
  always_ff @(posedge clk) begin
    neg_r <= diff[DIFF_W-1];
    mag_r <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    fac_r <= factor;
  end

  // Low half of the factor, rounded below the binary point
  assign lo_prod = PROD_W'(mag_r) * PROD_W'(fac_r[HALF_W-1:0]) + ROUND_HALF;

  always_ff @(posedge clk) begin
    lo_r <= lo_prod[PROD_W-1:HALF_W];
  end

  // High half of the factor plus the rounded low part
  always_ff @(posedge clk) begin
    q_r <= Q_W'(mag_r) * Q_W'(fac_r[WORD_W-1:HALF_W]) + Q_W'(lo_r);
  end

  // Restore sign and clamp to 32 bits
  always_comb begin
    if (neg_r) begin
      res_nxt = (q_r > NEG_LIMIT) ? WORD_W'(NEG_LIMIT) : WORD_W'(Q_W'(0) - q_r);
    end else begin
      res_nxt = (q_r > POS_LIMIT) ? WORD_W'(POS_LIMIT) : q_r[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result = $signed(res_r);

endmodule

@@ src/periodic_grid_central_difference.sv @@
// Top level of the periodic grid stencil: grid memory, sequencer and result register.
//
// Holds a GRID_SIDE x GRID_SIDE grid of signed Q16.16 samples in one single-port
// memory (one read or write per cycle, registered read data) and wraps indexes
// in both directions. A write word is stored from the idle state and yields no
// result. A query word reads the centre and its four wrapped neighbours one per
// cycle through the single memory port, forms the four differences, and runs
// them through four parallel four-stage scalers; its result enters the output
// register once that register is free, and the next word is taken only after
// that. The memory port and the scaler depth set how long a query takes. The
// output register lets a new word in while the previous result waits. Grid
// contents are undefined until written; there is no clearing pass after reset.
`include "periodic_grid_central_difference_defines.svh"

module periodic_grid_central_difference #(
  parameter int GRID_SIDE = pgcd_pkg::GRID_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pgcd_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pgcd_pkg::out_word_t                 out_word,
  input  logic                                cfg_wr_en,
  input  logic [pgcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pgcd_pkg::WORD_W-1:0]         cfg_data
);
  import pgcd_pkg::*;

  localparam int IDX_W     = $clog2(GRID_SIDE);
  localparam int MEM_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CNT_W     = 3;

  // Neighbor read slots
  localparam logic [CNT_W-1:0] SLOT_MID = 3'd0;
  localparam logic [CNT_W-1:0] SLOT_UP  = 3'd1;
  localparam logic [CNT_W-1:0] SLOT_DN  = 3'd2;
  localparam logic [CNT_W-1:0] SLOT_RT  = 3'd3;
  localparam logic [CNT_W-1:0] SLOT_LT  = 3'd4;
  localparam logic [CNT_W-1:0] NUM_READS = 3'd5;
  localparam logic [CNT_W-1:0] MATH_LAST = CNT_W'(SCALE_LAT - 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(GRID_SIDE - 1);

  // Reduce a 6-bit index modulo the grid side by restoring subtraction
  function automatic logic [IDX_W-1:0] wrap_index(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] t;
    t = v;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (32'(t) >= 32'(GRID_SIDE << k)) begin
        t = t - ROW_W'(GRID_SIDE << k);
      end
    end
    return IDX_W'(t);
  endfunction

  pgcd_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    row_r, col_r;
  logic [WORD_W-1:0]   inv_two_step_r, inv_step_squared_r;
  logic [WORD_W-1:0]   nb_r [5];
  logic signed [DIFF_W-1:0] d_fr_r, d_fc_r, d_sr_r, d_sc_r;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r;

  logic [WORD_W-1:0]   grid_mem [MEM_DEPTH];
  logic [WORD_W-1:0]   mem_q_r;
  logic                mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0]   mem_addr;
  logic [IDX_W-1:0]    acc_row, acc_col, rd_row, rd_col;
  logic [IDX_W-1:0]    row_up, row_dn, col_rt, col_lt;

  logic                in_take, query_take, nb_capture, diff_load, out_load;
  logic signed [WORD_W-1:0] res_fr, res_fc, res_sr, res_sc;

  assign in_take    = in_valid && in_ready;
  assign query_take = in_take && (in_word.action == ACT_QUERY);
  assign acc_row    = wrap_index(in_word.row);
  assign acc_col    = wrap_index(in_word.col);

  // Wrapped neighbor indexes
  assign row_up = (row_r == IDX_LAST) ? '0 : row_r + IDX_W'(1);
  assign row_dn = (row_r == '0) ? IDX_LAST : row_r - IDX_W'(1);
  assign col_rt = (col_r == IDX_LAST) ? '0 : col_r + IDX_W'(1);
  assign col_lt = (col_r == '0) ? IDX_LAST : col_r - IDX_W'(1);

  // Pick the point for the current read slot
  always_comb begin
    rd_row = row_r;
    rd_col = col_r;
    unique case (cnt_r)
      SLOT_UP:  rd_row = row_up;
      SLOT_DN:  rd_row = row_dn;
      SLOT_RT:  rd_col = col_rt;
      SLOT_LT:  rd_col = col_lt;
      default: begin
        rd_row = row_r;
        rd_col = col_r;
      end
    endcase
  end

  // Sequencer: next state and control
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_ready   = 1'b0;
    mem_wr_en  = 1'b0;
    mem_rd_en  = 1'b0;
    mem_addr   = ADDR_W'(rd_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(rd_col);
    nb_capture = 1'b0;
    diff_load  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_addr = ADDR_W'(acc_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(acc_col);
        if (in_valid) begin
          if (in_word.action == ACT_WRITE) begin
            mem_wr_en = 1'b1;
          end else begin
            state_nxt = ST_READ;
            cnt_nxt   = '0;
          end
        end
      end
      ST_READ: begin
        mem_rd_en  = (cnt_r != NUM_READS);
        nb_capture = (cnt_r != SLOT_MID);
        if (cnt_r == NUM_READS) begin
          state_nxt = ST_DIFF;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DIFF: begin
        diff_load = 1'b1;
        state_nxt = ST_MATH;
        cnt_nxt   = '0;
      end
      ST_MATH: begin
        if (cnt_r == MATH_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_two_step_r     <= INV_RESET;
      inv_step_squared_r <= INV_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_INV_TWO_STEP:     inv_two_step_r     <= cfg_data;
        CFG_INV_STEP_SQUARED: inv_step_squared_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Grid memory: one access per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      grid_mem[mem_addr] <= in_word.sample;
    end else if (mem_rd_en) begin
      mem_q_r <= grid_mem[mem_addr];
    end
  end

  // Hold the query point
  always_ff @(posedge clk) begin
    if (query_take) begin
      row_r <= acc_row;
      col_r <= acc_col;
    end
  end

  // Capture each neighbor in the cycle after its read, from the registered read data
  always_ff @(posedge clk) begin
    if (nb_capture) begin
      nb_r[cnt_r - CNT_W'(1)] <= mem_q_r;
    end
  end

  // Form the four differences exactly
  always_ff @(posedge clk) begin
    if (diff_load) begin
      d_fr_r <= DIFF_W'($signed(nb_r[SLOT_UP])) - DIFF_W'($signed(nb_r[SLOT_DN]));
      d_fc_r <= DIFF_W'($signed(nb_r[SLOT_RT])) - DIFF_W'($signed(nb_r[SLOT_LT]));
      d_sr_r <= DIFF_W'($signed(nb_r[SLOT_UP])) + DIFF_W'($signed(nb_r[SLOT_DN]))
                - (DIFF_W'($signed(nb_r[SLOT_MID])) <<< 1);
      d_sc_r <= DIFF_W'($signed(nb_r[SLOT_RT])) + DIFF_W'($signed(nb_r[SLOT_LT]))
                - (DIFF_W'($signed(nb_r[SLOT_MID])) <<< 1);
    end
  end

  // Four scaling lanes
  pgcd_scale u_scale_fr (.clk(clk), .diff(d_fr_r), .factor(inv_two_step_r),
                         .result(res_fr));
  pgcd_scale u_scale_fc (.clk(clk), .diff(d_fc_r), .factor(inv_two_step_r),
                         .result(res_fc));
  pgcd_scale u_scale_sr (.clk(clk), .diff(d_sr_r), .factor(inv_step_squared_r),
                         .result(res_sr));
  pgcd_scale u_scale_sc (.clk(clk), .diff(d_sc_r), .factor(inv_step_squared_r),
                         .result(res_sc));

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.first_along_rows  <= res_fr;
      out_word_r.first_along_cols  <= res_fc;
      out_word_r.second_along_rows <= res_sr;
      out_word_r.second_along_cols <= res_sc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  `PGCD_ASSERT_SAME(a_port_single, clk, rst_n, mem_wr_en, !mem_rd_en)
  `PGCD_ASSERT_SAME(a_write_idle, clk, rst_n, mem_wr_en, state_r == ST_IDLE && in_valid)
  `PGCD_ASSERT_SAME(a_addr_range, clk, rst_n, mem_wr_en || mem_rd_en,
                    32'(mem_addr) < 32'(MEM_DEPTH))
  `PGCD_ASSERT_NEXT(a_query_start, clk, rst_n, query_take,
                    state_r == ST_READ && cnt_r == SLOT_MID)
  `PGCD_ASSERT_NEXT(a_result_shown, clk, rst_n, out_load, out_valid_r)

endmodule
